// ===== hdl/scdm_pkg.sv =====
// Shared types and constants for the sorted coordinate duplicate merge block.
`default_nettype none

package scdm_pkg;

  // Field widths fixed by the interface
  localparam int unsigned NUM_PORTS      = 8;
  localparam int unsigned OUT_COORD_W    = 32;
  localparam int unsigned IN_COORD_W     = 32;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned SUM_W          = 48;
  localparam int unsigned CNT_W          = 32;
  localparam int unsigned CFG_W          = 4;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_MODES_DEF  = 8;
  localparam int unsigned COORD_BITS_DEF = 32;

  // Reset value of the mode count register
  localparam logic [CFG_W-1:0] NUM_MODES_RST = 4'd3;

  // Result queue sizing
  localparam int unsigned OQ_DEPTH       = 4;
  localparam int unsigned OQ_PTR_W       = 2;
  localparam int unsigned OQ_CNT_W       = 3;

  // Saturation limits of the running sum
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // One emitted entry
  typedef struct packed {
    logic [NUM_PORTS-1:0][OUT_COORD_W-1:0] coord;
    logic signed [SUM_W-1:0]               sum;
    logic                                  stream_end;
    logic [CNT_W-1:0]                      removed;
  } result_t;

endpackage : scdm_pkg

`default_nettype wire

// ===== hdl/scdm_result_queue.sv =====
// Small result queue that takes up to two entries per cycle and hands out one.
`default_nettype none

module scdm_result_queue
  import scdm_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [1:0]    push_cnt_i,
  input  wire result_t       push0_i,
  input  wire result_t       push1_i,
  output logic               room_o,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output result_t            pop_data_o
);

  result_t               mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OQ_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OQ_CNT_W-1:0]   count_q, count_d;
  logic [OQ_PTR_W-1:0]   wr_ptr_nxt;
  logic                  pop;

  // Space for a two-entry request is required before input is taken
  assign room_o      = (count_q <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign pop         = pop_valid_o & pop_ready_i;
  assign wr_ptr_nxt  = OQ_PTR_W'(wr_ptr_q + 1'b1);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = OQ_PTR_W'(wr_ptr_q + push_cnt_i);
    rd_ptr_d = pop ? OQ_PTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = OQ_CNT_W'(count_q + OQ_CNT_W'(push_cnt_i) - OQ_CNT_W'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push1_i;
    end
  end

endmodule : scdm_result_queue

`default_nettype wire

// ===== hdl/sorted_coordinate_duplicate_merge.sv =====
// Results are registered in the result queue before they reach the output.
// Throughput: one request per cycle while the result queue has room; a request that emits two
// entries fills two slots of the four-entry result queue, which drains one entry per cycle while out_ready_i is high.
// Input is taken while the result queue has two free slots.
// Reset clears the pending entry, its sum, the duplicate counter and the queue,
// and sets num_modes to 3.
`default_nettype none

module sorted_coordinate_duplicate_merge
  import scdm_pkg::*;
#(
  parameter int unsigned MAX_MODES  = MAX_MODES_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_W-1:0]          cfg_wdata_i,
  // input channel
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [IN_COORD_W-1:0]     coord_a_i,
  input  wire logic [IN_COORD_W-1:0]     coord_b_i,
  input  wire logic [IN_COORD_W-1:0]     coord_c_i,
  input  wire logic [IN_COORD_W-1:0]     coord_d_i,
  input  wire logic [IN_COORD_W-1:0]     coord_e_i,
  input  wire logic [IN_COORD_W-1:0]     coord_f_i,
  input  wire logic [IN_COORD_W-1:0]     coord_g_i,
  input  wire logic [IN_COORD_W-1:0]     coord_h_i,
  input  wire logic signed [VALUE_W-1:0] entry_value_i,
  input  wire logic                      is_final_i,
  // output channel
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [OUT_COORD_W-1:0]         out_a_o,
  output logic [OUT_COORD_W-1:0]         out_b_o,
  output logic [OUT_COORD_W-1:0]         out_c_o,
  output logic [OUT_COORD_W-1:0]         out_d_o,
  output logic [OUT_COORD_W-1:0]         out_e_o,
  output logic [OUT_COORD_W-1:0]         out_f_o,
  output logic [OUT_COORD_W-1:0]         out_g_o,
  output logic [OUT_COORD_W-1:0]         out_h_o,
  output logic signed [SUM_W-1:0]        merged_sum_o,
  output logic                           stream_end_o,
  output logic [CNT_W-1:0]               removed_count_o
);

  logic [CFG_W-1:0]                    num_modes_q;
  logic [CFG_W-1:0]                    n_act;
  logic                                pend_valid_q, pend_valid_d;
  logic [COORD_BITS-1:0]               pend_coord_q [MAX_MODES];
  logic signed [SUM_W-1:0]             pend_sum_q, pend_sum_d;
  logic [CNT_W-1:0]                    dup_cnt_q, dup_cnt_d;

  logic [NUM_PORTS-1:0][IN_COORD_W-1:0] in_coord;
  logic [MAX_MODES-1:0]                active;
  logic [MAX_MODES-1:0]                mode_ok;
  logic                                match;
  logic                                accept;
  logic                                miss;
  logic                                load;
  logic                                merge;
  logic signed [SUM_W:0]               sum_wide;
  logic signed [SUM_W-1:0]             sum_sat;
  logic signed [SUM_W-1:0]             new_sum;
  logic [CNT_W-1:0]                    new_cnt;

  result_t                             res_old;
  result_t                             res_new;
  result_t                             push0;
  result_t                             push1;
  logic [1:0]                          push_cnt;
  result_t                             head;
  logic                                room;

  assign in_coord = {coord_h_i, coord_g_i, coord_f_i, coord_e_i,
                     coord_d_i, coord_c_i, coord_b_i, coord_a_i};

  // Mode count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_modes_q <= NUM_MODES_RST;
    end else if (cfg_we_i) begin
      num_modes_q <= cfg_wdata_i;
    end
  end

  // Counts above the supported mode count act as the full count
  assign n_act = (num_modes_q > CFG_W'(MAX_MODES)) ? CFG_W'(MAX_MODES) : num_modes_q;

  // Per-mode compare and output masking
  for (genvar m = 0; m < MAX_MODES; m++) begin : g_mode
    assign active[m]  = (CFG_W'(m) < n_act);
    assign mode_ok[m] = ~active[m] |
                        (in_coord[m][COORD_BITS-1:0] == pend_coord_q[m]);
  end

  assign match = &mode_ok;

  for (genvar m = 0; m < NUM_PORTS; m++) begin : g_out
    if (m < MAX_MODES) begin : g_live
      // old entry uses stored coords, new entry uses what is stored after this step
      assign res_old.coord[m] = active[m] ? OUT_COORD_W'(pend_coord_q[m]) : '0;
      assign res_new.coord[m] = active[m] ?
          (load ? OUT_COORD_W'(in_coord[m][COORD_BITS-1:0]) : OUT_COORD_W'(pend_coord_q[m]))
          : '0;
    end else begin : g_dead
      assign res_old.coord[m] = '0;
      assign res_new.coord[m] = '0;
    end
  end

  // Step decode
  assign in_ready_o = room;
  assign accept     = in_valid_i & in_ready_o;
  assign miss       = pend_valid_q & ~match;
  assign merge      = pend_valid_q & match;
  assign load       = ~pend_valid_q | ~match;

  // Saturating add of the value into the pending sum
  assign sum_wide = {pend_sum_q[SUM_W-1], pend_sum_q} +
                    {{(SUM_W+1-VALUE_W){entry_value_i[VALUE_W-1]}}, entry_value_i};
  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  // State after the merge or swap, before the end-of-stream flush
  always_comb begin
    if (merge) begin
      new_sum = sum_sat;
      new_cnt = (dup_cnt_q != '1) ? CNT_W'(dup_cnt_q + 1'b1) : dup_cnt_q;
    end else begin
      new_sum = {{(SUM_W-VALUE_W){entry_value_i[VALUE_W-1]}}, entry_value_i};
      new_cnt = dup_cnt_q;
    end
  end

  // Emitted entries
  assign res_old.sum        = pend_sum_q;
  assign res_old.stream_end = 1'b0;
  assign res_old.removed    = '0;
  assign res_new.sum        = new_sum;
  assign res_new.stream_end = 1'b1;
  assign res_new.removed    = new_cnt;

  // Queue pushes: displaced entry first, then the end-of-stream flush
  always_comb begin
    push_cnt = 2'd0;
    push0    = res_old;
    push1    = res_new;
    if (accept) begin
      if (miss && is_final_i) begin
        push_cnt = 2'd2;
      end else if (miss) begin
        push_cnt = 2'd1;
      end else if (is_final_i) begin
        push_cnt = 2'd1;
        push0    = res_new;
      end
    end
  end

  // Next pending state
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_sum_d   = pend_sum_q;
    dup_cnt_d    = dup_cnt_q;
    if (accept) begin
      pend_sum_d = new_sum;
      if (is_final_i) begin
        pend_valid_d = 1'b0;
        dup_cnt_d    = '0;
      end else begin
        pend_valid_d = 1'b1;
        dup_cnt_d    = new_cnt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_sum_q   <= '0;
      dup_cnt_q    <= '0;
    end else begin
      pend_valid_q <= pend_valid_d;
      pend_sum_q   <= pend_sum_d;
      dup_cnt_q    <= dup_cnt_d;
    end
  end

  // Pending coordinates, payload only
  always_ff @(posedge clk_i) begin
    if (accept && load) begin
      for (int m = 0; m < MAX_MODES; m++) begin
        pend_coord_q[m] <= in_coord[m][COORD_BITS-1:0];
      end
    end
  end

  // Result queue
  scdm_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push0_i     (push0),
    .push1_i     (push1),
    .room_o      (room),
    .pop_valid_o (out_valid_o),
    .pop_ready_i (out_ready_i),
    .pop_data_o  (head)
  );

  assign out_a_o         = head.coord[0];
  assign out_b_o         = head.coord[1];
  assign out_c_o         = head.coord[2];
  assign out_d_o         = head.coord[3];
  assign out_e_o         = head.coord[4];
  assign out_f_o         = head.coord[5];
  assign out_g_o         = head.coord[6];
  assign out_h_o         = head.coord[7];
  assign merged_sum_o    = head.sum;
  assign stream_end_o    = head.stream_end;
  assign removed_count_o = head.removed;

`ifndef SYNTHESIS
  // A final request always leaves the block with no pending entry and a clear counter
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_final_i |=> !pend_valid_q && (dup_cnt_q == '0))
    else $error("final request did not clear pending state");

  // A non-final duplicate bumps the counter by one unless saturated
  a_dup_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && merge && !is_final_i && (dup_cnt_q != '1) |=>
      dup_cnt_q == CNT_W'($past(dup_cnt_q) + 1'b1))
    else $error("duplicate counter did not advance");

  // Without a request the pending state holds
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(pend_valid_q) && $stable(dup_cnt_q) && $stable(pend_sum_q))
    else $error("pending state changed without a request");

  // Only the end-of-stream entry carries a duplicate count
  a_count_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !stream_end_o |-> removed_count_o == '0)
    else $error("count reported on a non-final entry");
`endif

endmodule : sorted_coordinate_duplicate_merge

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sorted_coordinate_duplicate_merge: scoreboard, drivers, stimulus.
module testbench;
  import scdm_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1420;
  localparam int unsigned PHASE_ITEMS  = 120;
  localparam int unsigned DRAIN_CYCLES = 4;

  // One nonzero as it goes into the block
  typedef struct packed {
    logic [NUM_PORTS-1:0][IN_COORD_W-1:0] coord;
    logic signed [VALUE_W-1:0]            value;
    logic                                 is_final;
  } nonzero_t;

  // Tracks the merge state and the merged entries still owed by the block
  class merge_scoreboard;
    logic [CFG_W-1:0]                     num_modes;
    bit                                   pend_valid;
    logic [NUM_PORTS-1:0][IN_COORD_W-1:0] pend_coord;
    logic signed [SUM_W-1:0]              pend_sum;
    logic [CNT_W-1:0]                     dup_count;
    result_t                              merged_entries_q[$];
    int unsigned                          fail_count;
    int unsigned                          checked_count;
    int unsigned                          stream_count;

    function new();
      num_modes     = NUM_MODES_RST;
      pend_valid    = 1'b0;
      pend_coord    = '0;
      pend_sum      = '0;
      dup_count     = '0;
      fail_count    = 0;
      checked_count = 0;
      stream_count  = 0;
    endfunction

    function void set_modes(logic [CFG_W-1:0] v);
      num_modes = v;
    endfunction

    // Register values above the port count act as the port count
    function int unsigned active_modes();
      return (num_modes > NUM_PORTS) ? NUM_PORTS : num_modes;
    endfunction

    function void push_pending(bit at_end);
      result_t     r;
      int unsigned n;
      n = active_modes();
      for (int m = 0; m < NUM_PORTS; m++)
        r.coord[m] = (m < n) ? pend_coord[m] : '0;
      r.sum        = pend_sum;
      r.stream_end = at_end;
      r.removed    = at_end ? dup_count : '0;
      merged_entries_q.push_back(r);
    endfunction

    // Accepted request: merge, swap, and flush on the final one
    function void note_nonzero(nonzero_t nz);
      logic signed [SUM_W:0] wide;
      bit                    same;
      int unsigned           n;
      n    = active_modes();
      same = 1'b1;
      for (int m = 0; m < n; m++)
        if (nz.coord[m] != pend_coord[m]) same = 1'b0;
      if (!pend_valid) begin
        pend_coord = nz.coord;
        pend_sum   = $signed(nz.value);
        pend_valid = 1'b1;
      end else if (same) begin
        wide = $signed(pend_sum) + $signed(nz.value);
        if (wide[SUM_W] != wide[SUM_W-1])
          pend_sum = wide[SUM_W] ? SUM_MIN : SUM_MAX;
        else
          pend_sum = wide[SUM_W-1:0];
        if (dup_count != '1) dup_count++;
      end else begin
        push_pending(1'b0);
        pend_coord = nz.coord;
        pend_sum   = $signed(nz.value);
      end
      if (nz.is_final) begin
        push_pending(1'b1);
        pend_valid = 1'b0;
        dup_count  = '0;
        stream_count++;
      end
    endfunction

    // Accepted result: compare with the oldest merged entry owed
    function void check_entry(result_t got);
      result_t exp_r;
      if (merged_entries_q.size() == 0) begin
        $error("unexpected result: merged_sum %0d stream_end %0b", got.sum, got.stream_end);
        fail_count++;
        return;
      end
      exp_r = merged_entries_q.pop_front();
      checked_count++;
      for (int m = 0; m < NUM_PORTS; m++)
        if (got.coord[m] !== exp_r.coord[m]) begin
          $error("out_%c: expected 0x%08h, actual 0x%08h", 8'd97 + m[7:0],
                 exp_r.coord[m], got.coord[m]);
          fail_count++;
        end
      if (got.sum !== exp_r.sum) begin
        $error("merged_sum: expected %0d, actual %0d", exp_r.sum, got.sum);
        fail_count++;
      end
      if (got.stream_end !== exp_r.stream_end) begin
        $error("stream_end: expected %0b, actual %0b", exp_r.stream_end, got.stream_end);
        fail_count++;
      end
      if (got.removed !== exp_r.removed) begin
        $error("removed_count: expected %0d, actual %0d", exp_r.removed, got.removed);
        fail_count++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]          cfg_wdata_i   = '0;
  logic                      in_valid_i    = 1'b0;
  logic                      in_ready_o;
  logic [IN_COORD_W-1:0]     coord_a_i     = '0;
  logic [IN_COORD_W-1:0]     coord_b_i     = '0;
  logic [IN_COORD_W-1:0]     coord_c_i     = '0;
  logic [IN_COORD_W-1:0]     coord_d_i     = '0;
  logic [IN_COORD_W-1:0]     coord_e_i     = '0;
  logic [IN_COORD_W-1:0]     coord_f_i     = '0;
  logic [IN_COORD_W-1:0]     coord_g_i     = '0;
  logic [IN_COORD_W-1:0]     coord_h_i     = '0;
  logic signed [VALUE_W-1:0] entry_value_i = '0;
  logic                      is_final_i    = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i   = 1'b1;
  logic [OUT_COORD_W-1:0]    out_a_o, out_b_o, out_c_o, out_d_o;
  logic [OUT_COORD_W-1:0]    out_e_o, out_f_o, out_g_o, out_h_o;
  logic signed [SUM_W-1:0]   merged_sum_o;
  logic                      stream_end_o;
  logic [CNT_W-1:0]          removed_count_o;

  merge_scoreboard sb;
  nonzero_t        prev_nz      = '0;
  int unsigned     in_idle_pct  = 0;
  int unsigned     out_idle_pct = 0;
  int unsigned     out_hold     = 0;
  int unsigned     items_sent   = 0;
  int unsigned     cfg_writes   = 0;
  logic [15:0]     modes_used   = '0;

  sorted_coordinate_duplicate_merge uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .coord_a_i      (coord_a_i),
    .coord_b_i      (coord_b_i),
    .coord_c_i      (coord_c_i),
    .coord_d_i      (coord_d_i),
    .coord_e_i      (coord_e_i),
    .coord_f_i      (coord_f_i),
    .coord_g_i      (coord_g_i),
    .coord_h_i      (coord_h_i),
    .entry_value_i  (entry_value_i),
    .is_final_i     (is_final_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_a_o        (out_a_o),
    .out_b_o        (out_b_o),
    .out_c_o        (out_c_o),
    .out_d_o        (out_d_o),
    .out_e_o        (out_e_o),
    .out_f_o        (out_f_o),
    .out_g_o        (out_g_o),
    .out_h_o        (out_h_o),
    .merged_sum_o   (merged_sum_o),
    .stream_end_o   (stream_end_o),
    .removed_count_o(removed_count_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(99, 0) >= pct) return 0;
    if ($urandom_range(9, 0) == 0) return $urandom_range(30, 8);
    return $urandom_range(3, 1);
  endfunction

  // Output backpressure
  always @(posedge clk_i) begin : ready_gen
    int unsigned gap;
    if (out_hold != 0) begin
      out_hold <= out_hold - 1;
    end else begin
      gap = pick_gap(out_idle_pct);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        out_hold    <= gap - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Sample handshakes and register writes on the same edge the block sees them
  always @(posedge clk_i) begin : monitor
    result_t  got;
    nonzero_t seen;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.coord      = {out_h_o, out_g_o, out_f_o, out_e_o,
                          out_d_o, out_c_o, out_b_o, out_a_o};
        got.sum        = merged_sum_o;
        got.stream_end = stream_end_o;
        got.removed    = removed_count_o;
        sb.check_entry(got);
      end
      if (in_valid_i && in_ready_o) begin
        seen.coord    = {coord_h_i, coord_g_i, coord_f_i, coord_e_i,
                         coord_d_i, coord_c_i, coord_b_i, coord_a_i};
        seen.value    = entry_value_i;
        seen.is_final = is_final_i;
        sb.note_nonzero(seen);
      end
      if (cfg_we_i) sb.set_modes(cfg_wdata_i);
    end
  end

  task automatic pause_input(int unsigned cycles);
    if (cycles != 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Drive one request and hold it until taken
  task automatic send_nonzero(nonzero_t nz);
    in_valid_i    <= 1'b1;
    coord_a_i     <= nz.coord[0];
    coord_b_i     <= nz.coord[1];
    coord_c_i     <= nz.coord[2];
    coord_d_i     <= nz.coord[3];
    coord_e_i     <= nz.coord[4];
    coord_f_i     <= nz.coord[5];
    coord_g_i     <= nz.coord[6];
    coord_h_i     <= nz.coord[7];
    entry_value_i <= nz.value;
    is_final_i    <= nz.is_final;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    prev_nz = nz;
    pause_input(pick_gap(in_idle_pct));
  endtask

  // Wait until every owed entry has come out, then let the pipeline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.merged_entries_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_modes(logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_writes++;
    modes_used[v] = 1'b1;
  endtask

  function automatic nonzero_t uniform_nz(logic [IN_COORD_W-1:0] c, logic [VALUE_W-1:0] v,
                                          bit fin);
    nonzero_t nz;
    for (int m = 0; m < NUM_PORTS; m++) nz.coord[m] = c;
    nz.value    = v;
    nz.is_final = fin;
    return nz;
  endfunction

  // Next nonzero of a sorted-looking stream: repeats, small steps in one mode, some noise
  function automatic nonzero_t random_nonzero(bit fin);
    nonzero_t    nz;
    int unsigned pick;
    int unsigned m;
    nz   = prev_nz;
    pick = $urandom_range(99, 0);
    m    = $urandom_range(NUM_PORTS - 1, 0);
    if (pick >= 90)
      nz.coord[m] = $urandom_range(1, 0) ? '1 : '0;
    else if (pick >= 75)
      for (int i = 0; i < NUM_PORTS; i++) nz.coord[i] = $urandom();
    else if (pick >= 40)
      nz.coord[m] = prev_nz.coord[m] + $urandom_range(4, 1);
    pick = $urandom_range(99, 0);
    if (pick < 65)      nz.value = $urandom();
    else if (pick < 80) nz.value = $urandom_range(512, 0) - 256;
    else if (pick < 90) nz.value = 32'h7FFF_FFFF;
    else                nz.value = 32'h8000_0000;
    nz.is_final = fin;
    return nz;
  endfunction

  // Stimulus
  initial begin : stimulus
    nonzero_t    nz;
    int unsigned random_items;
    int unsigned phase_end;
    int unsigned phase;
    int unsigned len;
    bit          closed;
    logic [CFG_W-1:0] mode;
    random_items = 0;
    phase        = 0;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset mode count of three: lone final, zero entry, merge, swap, inactive-mode merge
    send_nonzero(uniform_nz('1, 32'h7FFF_FFFF, 1'b1));
    send_nonzero(uniform_nz('0, '0, 1'b1));
    nz = uniform_nz(32'h10, 32'h8000_0000, 1'b0);
    send_nonzero(nz);
    send_nonzero(nz);
    nz.coord[2] = nz.coord[2] + 1;
    nz.value    = 5;
    send_nonzero(nz);
    nz.coord[5] = '1;
    nz.value    = -3;
    send_nonzero(nz);
    nz.coord[0] = 32'h11;
    nz.is_final = 1'b1;
    send_nonzero(nz);

    // No modes compared: everything after the first merges, coordinates read as zero
    wait_idle();
    write_modes(4'd0);
    send_nonzero(uniform_nz(32'h1234, 100, 1'b0));
    send_nonzero(uniform_nz(32'hABCD, 200, 1'b0));
    send_nonzero(uniform_nz($urandom(), -50, 1'b1));

    // Mode count above the port count: all eight modes compared
    wait_idle();
    write_modes(4'd15);
    nz = uniform_nz(7, 1, 1'b0);
    send_nonzero(nz);
    nz.coord[7] = 8;
    send_nonzero(nz);
    nz.is_final = 1'b1;
    send_nonzero(nz);

    // Register change while an entry is pending
    wait_idle();
    write_modes(4'd8);
    nz = uniform_nz(9, 2, 1'b0);
    send_nonzero(nz);
    wait_idle();
    write_modes(4'd2);
    nz.coord[4] = 77;
    send_nonzero(nz);
    nz.coord[1] = 10;
    nz.is_final = 1'b1;
    send_nonzero(nz);

    // One mode: only mode 0 decides
    wait_idle();
    write_modes(4'd1);
    nz = uniform_nz(3, -1, 1'b0);
    send_nonzero(nz);
    for (int i = 1; i < NUM_PORTS; i++) nz.coord[i] = $urandom();
    nz.is_final = 1'b1;
    send_nonzero(nz);

    // Random streams, a new mode count and idling pattern per phase
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      case (phase)
        0:       mode = 4'd1;
        1:       mode = 4'd8;
        2:       mode = 4'd0;
        3:       mode = 4'd15;
        4:       mode = 4'd9;
        5:       mode = 4'd4;
        default: mode = $urandom_range(15, 0);
      endcase
      write_modes(mode);
      case (phase % 4)
        0:       begin in_idle_pct = 0;  out_idle_pct = 0;  end
        1:       begin in_idle_pct = 25; out_idle_pct = 25; end
        2:       begin in_idle_pct = 60; out_idle_pct = 10; end
        default: begin in_idle_pct = 10; out_idle_pct = 60; end
      endcase
      phase_end = random_items + PHASE_ITEMS;
      while (random_items < phase_end && random_items < RANDOM_ITEMS) begin
        len    = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        // a few streams are left open and run on into the next one
        closed = ($urandom_range(9, 0) != 0);
        for (int k = 0; k < len; k++)
          send_nonzero(random_nonzero(closed && (k == len - 1)));
        random_items += len;
      end
      phase++;
    end

    // Flush whatever is still pending and drain
    send_nonzero(random_nonzero(1'b1));
    wait_idle();

    $display("Run covered %0d requests (%0d random) in %0d streams, %0d entries checked",
             items_sent, random_items, sb.stream_count, sb.checked_count);
    $display("Mode count settings used (bit per value): %b over %0d register writes",
             modes_used, cfg_writes);
    if (sb.fail_count == 0 && sb.merged_entries_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #15_000_000;
    $display("Timeout: stimulus or drain did not complete");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/scdm_pkg.sv
hdl/scdm_result_queue.sv
hdl/sorted_coordinate_duplicate_merge.sv
dv/testbench.sv
